// ===== rtl/core/slcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types and constants for the sync/length/CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

    localparam logic [7:0]  FRAME_SYNC    = 8'hA5;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [7:0]  DEFAULT_LIMIT = 8'd160;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIVER_LIMIT = 8'd1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SYNC = 2'd1,
        ST_LEN_HIGH = 2'd2,
        ST_CRC_BAD  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRCLO   = 5'b01000,
        PH_CRCHI   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        status_t    status;
        logic [7:0] delivered_count;
    } result_t;

endpackage

// ===== rtl/core/slcfr_channels.sv =====
// ----------------------------------------------------------------------------
// slcfr channels
// Valid/ready channel interfaces for received bytes, results and register
// writes.
// ----------------------------------------------------------------------------
interface slcfr_rx_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [7:0] rx_byte;

    modport source (output valid, output restart, output rx_byte, input ready);
    modport sink   (input valid, input restart, input rx_byte, output ready);
endinterface

interface slcfr_res_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [7:0]           data_byte;
    logic [7:0]           position;
    slcfr_pkg::status_t   status;
    logic [7:0]           delivered_count;

    modport source (output valid, output kind, output data_byte, output position,
                    output status, output delivered_count, input ready);
    modport sink   (input valid, input kind, input data_byte, input position,
                    input status, input delivered_count, output ready);
endinterface

interface slcfr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slcfr_pkg::CFG_INDEX_W-1:0] index;
    logic [7:0]                        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/slcfr_crc_step.sv =====
// ----------------------------------------------------------------------------
// slcfr_crc_step
// One byte of CRC-16 CCITT update, polynomial 0x1021, MSB first.
// ----------------------------------------------------------------------------
module slcfr_crc_step
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((acc & slcfr_pkg::CRC_TOP) != 16'h0000)
            begin
                acc = {acc[14:0], 1'b0} ^ slcfr_pkg::CRC_POLY;
            end
            else
            begin
                acc = {acc[14:0], 1'b0};
            end
        end
        crc_out = acc;
    end

endmodule

// ===== rtl/core/slcfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slcfr_cfg_regs
// Maximum length and delivery limit registers, written over the config channel.
// ----------------------------------------------------------------------------
module slcfr_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    slcfr_cfg_if.sink         cfg,
    output logic [7:0]        max_payload,
    output logic [7:0]        deliver_limit
);

    logic [7:0] max_payload_reg;
    logic [7:0] deliver_limit_reg;

    assign cfg.ready     = 1'b1;
    assign max_payload   = max_payload_reg;
    assign deliver_limit = deliver_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg   <= slcfr_pkg::DEFAULT_LIMIT;
            deliver_limit_reg <= slcfr_pkg::DEFAULT_LIMIT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                slcfr_pkg::REG_MAX_PAYLOAD:   max_payload_reg   <= cfg.data;
                slcfr_pkg::REG_DELIVER_LIMIT: deliver_limit_reg <= cfg.data;
                default:                      ;
            endcase
        end
    end

endmodule

// ===== rtl/core/slcfr_parser.sv =====
// ----------------------------------------------------------------------------
// slcfr_parser
// Frame phase tracking, CRC accumulation and result generation per item.
// ----------------------------------------------------------------------------
module slcfr_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                restart,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          max_payload,
    input  logic [7:0]          deliver_limit,
    output logic                emit,
    output slcfr_pkg::result_t  result
);

    slcfr_pkg::phase_t phase_reg, phase_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        idx_reg, idx_next;
    logic [7:0]        low_reg, low_next;

    logic [15:0]       crc_base;
    logic [15:0]       crc_step;
    logic [7:0]        idx_inc;

    assign crc_base = restart ? slcfr_pkg::CRC_INIT : crc_reg;
    assign idx_inc  = idx_reg + 8'd1;

    slcfr_crc_step u_crc
    (
        .crc_in  (crc_base),
        .data_in (rx_byte),
        .crc_out (crc_step)
    );

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        emit       = 1'b0;
        result     = '{kind: slcfr_pkg::KIND_END, data_byte: 8'h00, position: 8'h00,
                       status: slcfr_pkg::ST_OK, delivered_count: 8'h00};

        if (restart)
        begin
            len_next = 8'h00;
            idx_next = 8'h00;
            low_next = 8'h00;
            if (rx_byte != slcfr_pkg::FRAME_SYNC)
            begin
                crc_next      = slcfr_pkg::CRC_INIT;
                emit          = 1'b1;
                result.status = slcfr_pkg::ST_BAD_SYNC;
                phase_next    = slcfr_pkg::PH_IDLE;
            end
            else
            begin
                crc_next   = crc_step;
                phase_next = slcfr_pkg::PH_LENGTH;
            end
        end
        else
        begin
            unique case (phase_reg)
                slcfr_pkg::PH_LENGTH:
                begin
                    len_next = rx_byte;
                    if (rx_byte > max_payload)
                    begin
                        emit          = 1'b1;
                        result.status = slcfr_pkg::ST_LEN_HIGH;
                        phase_next    = slcfr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        crc_next   = crc_step;
                        idx_next   = 8'h00;
                        phase_next = (rx_byte == 8'h00) ? slcfr_pkg::PH_CRCLO
                                                        : slcfr_pkg::PH_PAYLOAD;
                    end
                end
                slcfr_pkg::PH_PAYLOAD:
                begin
                    crc_next = crc_step;
                    if (idx_reg < deliver_limit)
                    begin
                        emit             = 1'b1;
                        result.kind      = slcfr_pkg::KIND_DATA;
                        result.data_byte = rx_byte;
                        result.position  = idx_reg;
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= len_reg)
                    begin
                        phase_next = slcfr_pkg::PH_CRCLO;
                    end
                end
                slcfr_pkg::PH_CRCLO:
                begin
                    low_next   = rx_byte;
                    phase_next = slcfr_pkg::PH_CRCHI;
                end
                slcfr_pkg::PH_CRCHI:
                begin
                    emit       = 1'b1;
                    phase_next = slcfr_pkg::PH_IDLE;
                    if ({rx_byte, low_reg} != crc_reg)
                    begin
                        result.status = slcfr_pkg::ST_CRC_BAD;
                    end
                    else
                    begin
                        result.delivered_count = (len_reg < deliver_limit) ? len_reg
                                                                           : deliver_limit;
                    end
                end
                default:
                begin
                    phase_next = slcfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= slcfr_pkg::PH_IDLE;
            crc_reg   <= slcfr_pkg::CRC_INIT;
            len_reg   <= 8'h00;
            idx_reg   <= 8'h00;
            low_reg   <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            low_reg   <= low_next;
        end
    end

endmodule

// ===== rtl/core/slcfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// slcfr_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module slcfr_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  slcfr_pkg::result_t  result,
    output logic                free,
    slcfr_res_if.source         res
);

    logic               valid_reg;
    slcfr_pkg::result_t data_reg;

    assign free                = !valid_reg || res.ready;
    assign res.valid           = valid_reg;
    assign res.kind            = data_reg.kind;
    assign res.data_byte       = data_reg.data_byte;
    assign res.position        = data_reg.position;
    assign res.status          = data_reg.status;
    assign res.delivered_count = data_reg.delivered_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // hold payload until a new item replaces it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/sync_len_crc16_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sync_len_crc16_frame_receiver_unit
// Deframer for sync 0xA5 / length / payload / CRC-16 CCITT frames.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle. Each item is decoded in the cycle
// it is accepted and its result, if any, appears in the result register on
// the next cycle, and the unit sustains a throughput of one item per
// cycle; the input stalls only while a result sits unread in the result
// register. Payload bytes below the delivery limit stream out as they arrive
// and must be dropped by the consumer if the frame-end status is not ok.
// Register writes take effect at once and belong between frames.
// ----------------------------------------------------------------------------
module sync_len_crc16_frame_receiver_unit
(
    input  logic        clk,
    input  logic        rst_n,
    slcfr_rx_if.sink    rx,
    slcfr_res_if.source res,
    slcfr_cfg_if.sink   cfg
);

    logic               accept;
    logic               free;
    logic               emit;
    slcfr_pkg::result_t result;
    logic [7:0]         max_payload;
    logic [7:0]         deliver_limit;

    assign rx.ready = free;
    assign accept   = rx.valid && free;

    slcfr_cfg_regs u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .max_payload   (max_payload),
        .deliver_limit (deliver_limit)
    );

    slcfr_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .restart       (rx.restart),
        .rx_byte       (rx.rx_byte),
        .max_payload   (max_payload),
        .deliver_limit (deliver_limit),
        .emit          (emit),
        .result        (result)
    );

    slcfr_out_reg u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && emit),
        .result (result),
        .free   (free),
        .res    (res)
    );

endmodule

// ===== rtl/core/slcfr_checker.sv =====
// ----------------------------------------------------------------------------
// slcfr_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slcfr_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic       res_kind,
    input  logic [7:0] res_data_byte,
    input  logic [7:0] res_position,
    input  logic [1:0] res_status,
    input  logic [7:0] res_delivered_count
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_rx_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rx_ready == (!res_valid || res_ready))
        else $error("input stalled without a pending result");

    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready))
        else $error("result without an accepted item");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == slcfr_pkg::KIND_DATA |->
            res_status == slcfr_pkg::ST_OK && res_delivered_count == 8'h00)
        else $error("payload item carries frame-end fields");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == slcfr_pkg::KIND_END |->
            res_data_byte == 8'h00 && res_position == 8'h00)
        else $error("frame-end item carries payload fields");

endmodule

bind sync_len_crc16_frame_receiver_unit slcfr_checker u_slcfr_checker
(
    .clk                 (clk),
    .rst_n               (rst_n),
    .rx_valid            (rx.valid),
    .rx_ready            (rx.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_kind            (res.kind),
    .res_data_byte       (res.data_byte),
    .res_position        (res.position),
    .res_status          (res.status),
    .res_delivered_count (res.delivered_count)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sync_len_crc16_frame_receiver_unit. A directed
// script of frames (bad sync, over-long length, empty payload, CRC good and
// bad, restarts mid-frame) runs first, then random frames are sent under a
// series of register settings. Each result is checked against the script's
// typed result or a bench deframer with own CRC-16 and register copies. The
// sender idles in bursts, result side stalls at random and with long hold-offs.
// ----------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_HI_BAD
    } byte_src_t;

    typedef struct {
        logic                restart;
        logic [7:0]          value;
        byte_src_t           src;
        bit                  typed;
        bit                  has_res;
        slcfr_pkg::result_t  res;
    } step_row_t;

    localparam int SCRIPT_LEN = 26;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 150;

    localparam slcfr_pkg::result_t NONE_R       = '0;
    localparam slcfr_pkg::result_t END_BAD_SYNC = {slcfr_pkg::KIND_END, 8'h00, 8'h00,
                                                   slcfr_pkg::ST_BAD_SYNC, 8'h00};
    localparam slcfr_pkg::result_t END_LEN_HIGH = {slcfr_pkg::KIND_END, 8'h00, 8'h00,
                                                   slcfr_pkg::ST_LEN_HIGH, 8'h00};
    localparam slcfr_pkg::result_t END_CRC_BAD  = {slcfr_pkg::KIND_END, 8'h00, 8'h00,
                                                   slcfr_pkg::ST_CRC_BAD, 8'h00};
    localparam slcfr_pkg::result_t END_OK_ZERO  = {slcfr_pkg::KIND_END, 8'h00, 8'h00,
                                                   slcfr_pkg::ST_OK, 8'h00};

    logic clk;
    logic rst_n;

    slcfr_rx_if  rx();
    slcfr_res_if res();
    slcfr_cfg_if cfg();

    sync_len_crc16_frame_receiver_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    // deframer state and register copies
    slcfr_pkg::phase_t rx_phase;
    logic [15:0]       crc_run;
    logic [7:0]        frame_len;
    logic [7:0]        pay_idx;
    logic [7:0]        crc_low;
    logic [7:0]        max_len;
    logic [7:0]        deliver_lim;

    slcfr_pkg::result_t expected_out[$];
    int                 mismatch_count;
    int                 items_sent;
    int                 burst_left;

    step_row_t script [SCRIPT_LEN];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3600000;
        $display("status: fail");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ slcfr_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic bit deframe(input logic rs, input logic [7:0] b,
                                   output slcfr_pkg::result_t r);
        bit got;
        got = 1'b0;
        r   = '0;
        if (rs)
        begin
            crc_run   = slcfr_pkg::CRC_INIT;
            frame_len = 8'd0;
            pay_idx   = 8'd0;
            crc_low   = 8'd0;
            if (b != slcfr_pkg::FRAME_SYNC)
            begin
                r.kind   = slcfr_pkg::KIND_END;
                r.status = slcfr_pkg::ST_BAD_SYNC;
                got      = 1'b1;
                rx_phase = slcfr_pkg::PH_IDLE;
            end
            else
            begin
                crc_run  = crc16_byte(crc_run, b);
                rx_phase = slcfr_pkg::PH_LENGTH;
            end
        end
        else
        begin
            case (rx_phase)
                slcfr_pkg::PH_LENGTH:
                begin
                    frame_len = b;
                    if (b > max_len)
                    begin
                        r.kind   = slcfr_pkg::KIND_END;
                        r.status = slcfr_pkg::ST_LEN_HIGH;
                        got      = 1'b1;
                        rx_phase = slcfr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        crc_run  = crc16_byte(crc_run, b);
                        pay_idx  = 8'd0;
                        rx_phase = (b == 8'd0) ? slcfr_pkg::PH_CRCLO : slcfr_pkg::PH_PAYLOAD;
                    end
                end
                slcfr_pkg::PH_PAYLOAD:
                begin
                    crc_run = crc16_byte(crc_run, b);
                    if (pay_idx < deliver_lim)
                    begin
                        r.kind      = slcfr_pkg::KIND_DATA;
                        r.data_byte = b;
                        r.position  = pay_idx;
                        got         = 1'b1;
                    end
                    pay_idx = pay_idx + 8'd1;
                    if (pay_idx >= frame_len)
                        rx_phase = slcfr_pkg::PH_CRCLO;
                end
                slcfr_pkg::PH_CRCLO:
                begin
                    crc_low  = b;
                    rx_phase = slcfr_pkg::PH_CRCHI;
                end
                slcfr_pkg::PH_CRCHI:
                begin
                    r.kind = slcfr_pkg::KIND_END;
                    got    = 1'b1;
                    if ({b, crc_low} != crc_run)
                        r.status = slcfr_pkg::ST_CRC_BAD;
                    else
                    begin
                        r.status          = slcfr_pkg::ST_OK;
                        r.delivered_count = (frame_len < deliver_lim) ? frame_len : deliver_lim;
                    end
                    rx_phase = slcfr_pkg::PH_IDLE;
                end
                default:
                    rx_phase = slcfr_pkg::PH_IDLE;
            endcase
        end
        return got;
    endfunction

    task automatic send_byte(input logic rs, input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_has = 1'b0,
                             input slcfr_pkg::result_t typed_res = '0);
        bit                 got;
        bit                 counted;
        slcfr_pkg::result_t r;
        rx.valid   <= 1'b1;
        rx.restart <= rs;
        rx.rx_byte <= b;
        do @(posedge clk); while (!rx.ready);
        counted = rs || (rx_phase != slcfr_pkg::PH_IDLE);
        got = deframe(rs, b, r);
        if (typed)
        begin
            got = typed_has;
            r   = typed_res;
        end
        if (got)
            expected_out.push_back(r);
        if (counted)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
        end
    endtask

    task automatic write_reg(input logic [slcfr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        if (idx == slcfr_pkg::REG_MAX_PAYLOAD)
            max_len = val;
        else if (idx == slcfr_pkg::REG_DELIVER_LIMIT)
            deliver_lim = val;
    endtask

    task automatic drain();
        rx.valid <= 1'b0;
        while (expected_out.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_frame();
        int          flen_r;
        int          cut;
        logic [15:0] spoil;
        if ($urandom_range(0, 11) == 0)
        begin
            send_byte(1'b1, 8'($urandom));
            return;
        end
        send_byte(1'b1, slcfr_pkg::FRAME_SYNC);
        flen_r = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0 && max_len < 8'hFF)
            flen_r = int'(max_len) + 1;
        cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, flen_r + 1) : -1;
        send_byte(1'b0, 8'(flen_r));
        if (rx_phase == slcfr_pkg::PH_IDLE)
            return;
        for (int i = 0; i < flen_r; i++)
        begin
            if (i == cut)
                return;
            send_byte(1'b0, 8'($urandom));
        end
        if (cut == flen_r)
            return;
        spoil = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        send_byte(1'b0, crc_run[7:0] ^ spoil[7:0]);
        if (cut == flen_r + 1)
            return;
        send_byte(1'b0, crc_run[15:8] ^ spoil[15:8]);
    endtask

    // result side: check, stall at random, hold off now and then
    initial
    begin
        int                 hold_left;
        int                 stall_pct;
        int                 next_hold;
        int                 tick;
        slcfr_pkg::result_t want;
        hold_left = 0;
        stall_pct = 0;
        next_hold = 250;
        tick      = 0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (expected_out.size() == 0)
                    note_mismatch($sformatf("unexpected result kind %0b data %02x pos %0d st %0d n %0d",
                                            res.kind, res.data_byte, res.position,
                                            res.status, res.delivered_count));
                else
                begin
                    want = expected_out.pop_front();
                    if (res.kind !== want.kind || res.data_byte !== want.data_byte ||
                        res.position !== want.position || res.status !== want.status ||
                        res.delivered_count !== want.delivered_count)
                        note_mismatch($sformatf(
                            "got kind %0b data %02x pos %0d st %0d n %0d, want %0b %02x %0d %0d %0d",
                            res.kind, res.data_byte, res.position, res.status,
                            res.delivered_count, want.kind, want.data_byte, want.position,
                            want.status, want.delivered_count));
                end
            end
            tick++;
            if (tick % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_left == 0 && items_sent >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold += 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        logic [7:0] b;
        logic [7:0] setting_max   [8];
        logic [7:0] setting_limit [8];
        int         start_count;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 0;
        rst_n      <= 1'b0;
        rx.valid   <= 1'b0;
        rx.restart <= 1'b0;
        rx.rx_byte <= 8'h00;
        cfg.valid  <= 1'b0;
        cfg.index  <= '0;
        cfg.data   <= 8'h00;

        max_len     = slcfr_pkg::DEFAULT_LIMIT;
        deliver_lim = slcfr_pkg::DEFAULT_LIMIT;
        rx_phase    = slcfr_pkg::PH_IDLE;
        crc_run     = slcfr_pkg::CRC_INIT;
        frame_len   = 8'd0;
        pay_idx     = 8'd0;
        crc_low     = 8'd0;

        script = '{
            '{1'b0, 8'h00, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b1, 8'h00, SRC_LIT,        1'b1, 1'b1, END_BAD_SYNC},
            '{1'b1, 8'hFF, SRC_LIT,        1'b1, 1'b1, END_BAD_SYNC},
            '{1'b1, 8'hA5, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b0, 8'hFF, SRC_LIT,        1'b1, 1'b1, END_LEN_HIGH},
            '{1'b1, 8'hA5, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_LO,     1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_HI,     1'b1, 1'b1, END_OK_ZERO},
            '{1'b1, 8'hA5, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h03, SRC_LIT,        1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_LIT,        1'b1, 1'b1,
              {slcfr_pkg::KIND_DATA, 8'h00, 8'd0, slcfr_pkg::ST_OK, 8'd0}},
            '{1'b0, 8'hFF, SRC_LIT,        1'b1, 1'b1,
              {slcfr_pkg::KIND_DATA, 8'hFF, 8'd1, slcfr_pkg::ST_OK, 8'd0}},
            '{1'b0, 8'h80, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_LO,     1'b1, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_HI_BAD, 1'b1, 1'b1, END_CRC_BAD},
            '{1'b1, 8'hA5, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'hA0, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b1, 8'hA5, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h01, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'hAA, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_LO,     1'b0, 1'b0, NONE_R},
            '{1'b1, 8'hA5, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_LIT,        1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_LO,     1'b0, 1'b0, NONE_R},
            '{1'b0, 8'h00, SRC_CRC_HI,     1'b0, 1'b0, NONE_R}
        };

        setting_max   = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd12, 8'd0, 8'd0, 8'd0};
        setting_limit = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd5, 8'd0, 8'd0, 8'd0};
        for (int s = 5; s < 8; s++)
        begin
            setting_max[s]   = 8'($urandom);
            setting_limit[s] = 8'($urandom_range(0, 16));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            case (script[i].src)
                SRC_CRC_LO:     b = crc_run[7:0];
                SRC_CRC_HI:     b = crc_run[15:8];
                SRC_CRC_HI_BAD: b = ~crc_run[15:8];
                default:        b = script[i].value;
            endcase
            send_byte(script[i].restart, b, script[i].typed, script[i].has_res, script[i].res);
        end

        for (int s = 0; s < 8; s++)
        begin
            drain();
            write_reg(slcfr_pkg::REG_MAX_PAYLOAD, setting_max[s]);
            write_reg(slcfr_pkg::CFG_INDEX_W'($urandom_range(2, 255)), 8'($urandom));
            write_reg(slcfr_pkg::REG_DELIVER_LIMIT, setting_limit[s]);
            cfg.valid <= 1'b0;
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS)
            begin
                send_frame();
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slcfr_pkg.sv
rtl/core/slcfr_channels.sv
rtl/core/slcfr_crc_step.sv
rtl/core/slcfr_cfg_regs.sv
rtl/core/slcfr_parser.sv
rtl/core/slcfr_out_reg.sv
rtl/core/sync_len_crc16_frame_receiver_unit.sv
rtl/core/slcfr_checker.sv
dv/tb.sv
